[sv/modbus_rtu_request_framer_unit_defines.svh]
// assertion macros for the modbus rtu request framer
`ifndef MODBUS_RTU_REQUEST_FRAMER_UNIT_DEFINES_SVH
`define MODBUS_RTU_REQUEST_FRAMER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MBRTU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define MBRTU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/mbrtu_pkg.sv]
// shared types, constants and crc step for the modbus rtu request framer
package mbrtu_pkg;

   localparam int FRAME_BYTES_DEF = 8;

   localparam logic [7:0]  MAX_DEVICE_INDEX_RST = 8'd6;
   localparam logic [7:0]  FC_READ              = 8'h03;
   localparam logic [7:0]  FC_WRITE             = 8'h06;
   localparam logic [15:0] CRC_INIT             = 16'hFFFF;
   localparam logic [15:0] CRC_POLY             = 16'hA001;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BAD_ID  = 2'd1;
   localparam logic [1:0] STATUS_BAD_FC  = 2'd2;
   localparam logic [1:0] STATUS_BAD_CRC = 2'd3;

   typedef struct packed {
      logic load;
      logic build;
      logic crc_clr;
      logic crc_step;
      logic crc_done;
      logic cnt_clr;
      logic cnt_inc;
      logic push_byte;
      logic push_err;
   } mbrtu_cmd_type;

   typedef struct packed {
      logic id_err;
      logic fc_err;
      logic crc_ones;
      logic cnt_crc_last;
      logic cnt_last;
      logic out_free;
   } mbrtu_sts_type;

   // reflected crc-16 over one byte
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

[sv/mbrtu_ctrl.sv]
// controller state machine for the modbus rtu request framer
module mbrtu_ctrl
   import mbrtu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  mbrtu_sts_type sts,
   output mbrtu_cmd_type cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_CHECK  = 6'b000010,
      S_CRC    = 6'b000100,
      S_CRCCHK = 6'b001000,
      S_ERR    = 6'b010000,
      S_EMIT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.crc_clr = 1'b1;
            cmd.cnt_clr = 1'b1;
            if (sts.id_err || sts.fc_err) begin
               state_in = S_ERR;
            end else begin
               cmd.build = 1'b1;
               state_in  = S_CRC;
            end
         end
         S_CRC: begin
            cmd.crc_step = 1'b1;
            if (sts.cnt_crc_last) begin
               cmd.cnt_clr = 1'b1;
               state_in    = S_CRCCHK;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         S_CRCCHK: begin
            if (sts.crc_ones) begin
               state_in = S_ERR;
            end else begin
               cmd.crc_done = 1'b1;
               state_in     = S_EMIT;
            end
         end
         S_ERR: begin
            if (sts.out_free) begin
               cmd.push_err = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.push_byte = 1'b1;
               if (sts.cnt_last) begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  cmd.cnt_inc = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/mbrtu_dpath.sv]
// datapath for the modbus rtu request framer: request, frame store, crc, output beat
module mbrtu_dpath
   import mbrtu_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write_enable,
   input  logic [7:0]    csr_write_data,
   input  logic [7:0]    req_device_index,
   input  logic [7:0]    req_function_code,
   input  logic [31:0]   req_descriptor,
   input  logic [15:0]   req_write_value,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [7:0]    rsp_frame_byte,
   output logic          rsp_last_byte,
   output logic [1:0]    rsp_status,
   input  mbrtu_cmd_type cmd,
   output mbrtu_sts_type sts
);

   localparam int CNT_W = $clog2(FRAME_BYTES);
   localparam logic [CNT_W-1:0] CRC_LAST_IDX = CNT_W'(FRAME_BYTES - 3);
   localparam logic [CNT_W-1:0] CRC_LO_IDX   = CNT_W'(FRAME_BYTES - 2);
   localparam logic [CNT_W-1:0] LAST_IDX     = CNT_W'(FRAME_BYTES - 1);

   logic [7:0]       max_device_index_ff;
   logic [7:0]       idx_ff;
   logic [7:0]       fc_ff;
   logic [31:0]      desc_ff;
   logic [15:0]      value_ff;
   logic [7:0]       frame_store_ff [FRAME_BYTES];
   logic [15:0]      crc_ff, crc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_frame_byte_ff;
   logic             rsp_last_byte_ff;
   logic [1:0]       rsp_status_ff;
   logic [1:0]       err_code;
   logic [7:0]       hi_byte, lo_byte;

   assign sts.id_err       = (idx_ff > max_device_index_ff);
   assign sts.fc_err       = ((desc_ff[2:0] & fc_ff[2:0]) == 3'b000);
   assign sts.crc_ones     = (crc_ff == CRC_INIT);
   assign sts.cnt_crc_last = (cnt_ff == CRC_LAST_IDX);
   assign sts.cnt_last     = (cnt_ff == LAST_IDX);
   assign sts.out_free     = !rsp_valid_ff || !rsp_stall;

   assign err_code = sts.id_err ? STATUS_BAD_ID : (sts.fc_err ? STATUS_BAD_FC : STATUS_BAD_CRC);

   always_comb begin
      hi_byte = 8'h00;
      lo_byte = 8'h00;
      if (fc_ff == FC_READ) begin
         lo_byte = desc_ff[15:8];
      end else if (fc_ff == FC_WRITE) begin
         hi_byte = value_ff[15:8];
         lo_byte = value_ff[7:0];
      end
   end

   always_comb begin
      crc_in = crc_ff;
      if (cmd.crc_clr) begin
         crc_in = CRC_INIT;
      end else if (cmd.crc_step) begin
         crc_in = crc_byte(crc_ff, frame_store_ff[cnt_ff]);
      end
      cnt_in = cnt_ff;
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.push_byte || cmd.push_err) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         max_device_index_ff <= MAX_DEVICE_INDEX_RST;
         crc_ff              <= CRC_INIT;
         cnt_ff              <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            max_device_index_ff <= csr_write_data;
         end
         crc_ff       <= crc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff   <= req_device_index;
         fc_ff    <= req_function_code;
         desc_ff  <= req_descriptor;
         value_ff <= req_write_value;
      end
      if (cmd.build) begin
         frame_store_ff[0] <= idx_ff + 8'd1;
         frame_store_ff[1] <= fc_ff;
         frame_store_ff[2] <= desc_ff[31:24];
         frame_store_ff[3] <= desc_ff[23:16];
         frame_store_ff[4] <= hi_byte;
         frame_store_ff[5] <= lo_byte;
      end
      if (cmd.crc_done) begin
         frame_store_ff[CRC_LO_IDX] <= crc_ff[7:0];
         frame_store_ff[LAST_IDX]   <= crc_ff[15:8];
      end
      if (cmd.push_byte) begin
         rsp_frame_byte_ff <= frame_store_ff[cnt_ff];
         rsp_last_byte_ff  <= sts.cnt_last;
         rsp_status_ff     <= STATUS_OK;
      end else if (cmd.push_err) begin
         rsp_frame_byte_ff <= 8'h00;
         rsp_last_byte_ff  <= 1'b1;
         rsp_status_ff     <= err_code;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_frame_byte_ff;
   assign rsp_last_byte  = rsp_last_byte_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

[sv/modbus_rtu_request_framer_unit.sv]
// top level of the modbus rtu request framer
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | device_index, function_code, descriptor, write_value
//  rsp     | out       | rsp_valid/stall   | frame_byte, last_byte, status
//  csr     | in        | csr_write_enable  | csr_write_data (max device index)
//
// one request at a time: a check state, a crc state that steps the six header bytes
// through the crc unit one byte per cycle, a crc check state, then one beat per cycle
// while rsp is not stalled; an error gives a single beat.
// the result register lets a new request be taken while the last beat still waits.
// synchronous active-high reset; max device index resets to 6.
module modbus_rtu_request_framer_unit
   import mbrtu_pkg::*;
#(
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_device_index,
   input  logic [7:0]  req_function_code,
   input  logic [31:0] req_descriptor,
   input  logic [15:0] req_write_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_last_byte,
   output logic [1:0]  rsp_status
);

   mbrtu_cmd_type cmd;
   mbrtu_sts_type sts;

   mbrtu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mbrtu_dpath #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_device_index  (req_device_index),
      .req_function_code (req_function_code),
      .req_descriptor    (req_descriptor),
      .req_write_value   (req_write_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_last_byte     (rsp_last_byte),
      .rsp_status        (rsp_status),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule

[sv/mbrtu_checker.sv]
// port-level checker for the modbus rtu request framer, bound to the top level
`include "modbus_rtu_request_framer_unit_defines.svh"

module mbrtu_checker
   import mbrtu_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_frame_byte,
   input logic       rsp_last_byte,
   input logic [1:0] rsp_status
);

   // error beat carries a zero byte and ends the request
   `MBRTU_ASSERT_NOW(a_err_beat, clock, reset, rsp_valid && (rsp_status != STATUS_OK), (rsp_frame_byte == 8'h00) && rsp_last_byte, "error beat with data or not last")

   // a beat that is not last is always a good frame byte
   `MBRTU_ASSERT_NOW(a_mid_ok, clock, reset, rsp_valid && !rsp_last_byte, rsp_status == STATUS_OK, "non-last beat with error status")

   // one request at a time
   `MBRTU_ASSERT_NEXT(a_one_req, clock, reset, req_valid && !req_stall, req_stall, "request taken while busy")

   // stalled beat holds
   `MBRTU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_frame_byte) && $stable(rsp_last_byte) && $stable(rsp_status), "stalled rsp beat changed")

endmodule

bind modbus_rtu_request_framer_unit mbrtu_checker u_checker (.*);

[tb/tb_modbus_rtu_request_framer_unit.sv]
`timescale 1ns / 100ps
// testbench for the modbus rtu request framer: every frame and error beat checked against a predictor
module tb_modbus_rtu_request_framer_unit;
   import mbrtu_pkg::*;

   localparam int          CYCLE_LIMIT  = 600000;
   localparam int          DRAIN_CYCLES = 40;
   localparam int          HOLDOFF_LEN  = 300;
   localparam logic [15:0] CRC_ALL_ONES = 16'hFFFF;

   typedef struct packed {
      logic [7:0]  device_index;
      logic [7:0]  function_code;
      logic [31:0] descriptor;
      logic [15:0] write_value;
   } framer_request_t;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
      logic [1:0] status;
   } frame_beat_t;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        csr_write_enable  = 1'b0;
   logic [7:0]  csr_write_data    = 8'h00;
   logic        req_valid         = 1'b0;
   logic        req_stall;
   logic [7:0]  req_device_index  = 8'h00;
   logic [7:0]  req_function_code = 8'h00;
   logic [31:0] req_descriptor    = 32'h0;
   logic [15:0] req_write_value   = 16'h0;
   logic        rsp_valid;
   logic        rsp_stall         = 1'b0;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_last_byte;
   logic [1:0]  rsp_status;

   frame_beat_t frame_beats_due[$];
   frame_beat_t due_beat;
   logic [7:0]  max_index_setting = MAX_DEVICE_INDEX_RST;
   logic        burst_mode        = 1'b0;
   int          holdoff_request   = 0;
   int          holdoffs_done     = 0;
   int          cycle_count       = 0;
   int          mismatch_count    = 0;
   int          requests_accepted = 0;
   int          beats_checked     = 0;
   int          good_frames       = 0;
   int          config_writes     = 0;
   int          status_seen [0:3] = '{0, 0, 0, 0};

   modbus_rtu_request_framer_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_device_index  (req_device_index),
      .req_function_code (req_function_code),
      .req_descriptor    (req_descriptor),
      .req_write_value   (req_write_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_last_byte     (rsp_last_byte),
      .rsp_status        (rsp_status)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still due", cycle_count,
                  frame_beats_due.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // reflected crc-16, one byte
   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] acc;
      acc = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
      end
      return acc;
   endfunction

   function automatic framer_request_t make_request(input logic [7:0] idx, input logic [7:0] fc,
                                                    input logic [31:0] desc,
                                                    input logic [15:0] value);
      return {idx, fc, desc, value};
   endfunction

   function automatic logic [31:0] make_descriptor(input logic [15:0] addr, input logic [7:0] len,
                                                   input logic [2:0] mask);
      return {addr, len, 5'b00000, mask};
   endfunction

   // write value that drives the crc of a write frame to all ones
   function automatic logic [15:0] crc_ones_write_value(input logic [7:0] idx,
                                                        input logic [15:0] addr);
      logic [15:0] prefix;
      logic [15:0] crc;
      logic [15:0] found_value;
      logic [7:0]  sent_id;
      logic        found;
      sent_id = idx + 8'd1;
      found = 1'b0;
      found_value = 16'h0000;
      prefix = crc16_step(CRC_INIT, sent_id);
      prefix = crc16_step(prefix, FC_WRITE);
      prefix = crc16_step(prefix, addr[15:8]);
      prefix = crc16_step(prefix, addr[7:0]);
      for (int v = 0; v < 65536; v++) begin
         crc = crc16_step(crc16_step(prefix, v[15:8]), v[7:0]);
         if (crc == CRC_ALL_ONES && !found) begin
            found = 1'b1;
            found_value = v[15:0];
         end
      end
      return found_value;
   endfunction

   task automatic push_error_beat(input logic [1:0] code);
      frame_beat_t beat;
      beat.frame_byte = 8'h00;
      beat.last_byte  = 1'b1;
      beat.status     = code;
      frame_beats_due.push_back(beat);
      status_seen[code]++;
   endtask

   task automatic queue_expected_beats(input framer_request_t rq);
      logic [7:0]  frame [0:7];
      logic [15:0] crc;
      logic [2:0]  fc_mask;
      frame_beat_t beat;
      fc_mask = rq.descriptor[2:0];
      requests_accepted++;
      if (rq.device_index > max_index_setting) begin
         push_error_beat(STATUS_BAD_ID);
      end else if (fc_mask == 3'b000 || (fc_mask & rq.function_code[2:0]) == 3'b000) begin
         push_error_beat(STATUS_BAD_FC);
      end else begin
         frame[0] = rq.device_index + 8'd1;
         frame[1] = rq.function_code;
         frame[2] = rq.descriptor[31:24];
         frame[3] = rq.descriptor[23:16];
         if (rq.function_code == FC_READ) begin
            frame[4] = 8'h00;
            frame[5] = rq.descriptor[15:8];
         end else if (rq.function_code == FC_WRITE) begin
            frame[4] = rq.write_value[15:8];
            frame[5] = rq.write_value[7:0];
         end else begin
            frame[4] = 8'h00;
            frame[5] = 8'h00;
         end
         crc = CRC_INIT;
         for (int i = 0; i < 6; i++) begin
            crc = crc16_step(crc, frame[i]);
         end
         if (crc == CRC_ALL_ONES) begin
            push_error_beat(STATUS_BAD_CRC);
         end else begin
            frame[6] = crc[7:0];
            frame[7] = crc[15:8];
            for (int i = 0; i < 8; i++) begin
               beat.frame_byte = frame[i];
               beat.last_byte  = (i == 7);
               beat.status     = STATUS_OK;
               frame_beats_due.push_back(beat);
            end
            good_frames++;
            status_seen[STATUS_OK]++;
         end
      end
   endtask

   // result beat checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_checked++;
         if (frame_beats_due.size() == 0) begin
            $error("unexpected beat: frame_byte %h last_byte %b status %0d",
                   rsp_frame_byte, rsp_last_byte, rsp_status);
            mismatch_count++;
         end else begin
            due_beat = frame_beats_due.pop_front();
            if (rsp_frame_byte !== due_beat.frame_byte) begin
               $error("frame_byte mismatch: expected %h, actual %h",
                      due_beat.frame_byte, rsp_frame_byte);
               mismatch_count++;
            end
            if (rsp_last_byte !== due_beat.last_byte) begin
               $error("last_byte mismatch: expected %b, actual %b",
                      due_beat.last_byte, rsp_last_byte);
               mismatch_count++;
            end
            if (rsp_status !== due_beat.status) begin
               $error("status mismatch: expected %0d, actual %0d", due_beat.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   // receiver stalls, with a long hold-off on request
   initial begin
      int pick;
      int stall_len;
      forever begin
         if (holdoff_request > 0) begin
            stall_len = holdoff_request;
            holdoff_request = 0;
            rsp_stall <= 1'b1;
            repeat (stall_len) @(negedge clock);
            holdoffs_done++;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
               rsp_stall <= 1'b0;
               stall_len = $urandom_range(1, 24);
            end else if (pick < 90) begin
               rsp_stall <= 1'b1;
               stall_len = $urandom_range(1, 3);
            end else begin
               rsp_stall <= 1'b1;
               stall_len = $urandom_range(8, 40);
            end
            repeat (stall_len) @(negedge clock);
         end
      end
   end

   function automatic int pick_req_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         return 0;
      end else if (pick < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // called at a falling edge; leaves valid high after the beat is taken
   task automatic send_request(input framer_request_t rq);
      int gap;
      gap = burst_mode ? 0 : pick_req_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_device_index  <= rq.device_index;
      req_function_code <= rq.function_code;
      req_descriptor    <= rq.descriptor;
      req_write_value   <= rq.write_value;
      req_valid         <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      queue_expected_beats(rq);
      @(negedge clock);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (frame_beats_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_max_index(input logic [7:0] value);
      wait_until_drained();
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      max_index_setting = value;
      config_writes++;
      @(negedge clock);
   endtask

   function automatic framer_request_t random_request(input logic [7:0] limit);
      framer_request_t rq;
      int              kind;
      int              sel;
      logic [1:0]      b;
      logic [2:0]      mask;
      logic [2:0]      low;
      kind = $urandom_range(0, 99);
      rq.device_index  = 8'($urandom_range(0, 255));
      rq.function_code = 8'($urandom_range(0, 255));
      rq.descriptor    = $urandom;
      rq.write_value   = 16'($urandom_range(0, 65535));
      if (kind < 75) begin
         rq.device_index = 8'($urandom_range(0, limit));
         sel = $urandom_range(0, 9);
         if (sel < 4) begin
            rq.function_code = FC_READ;
         end else if (sel < 8) begin
            rq.function_code = FC_WRITE;
         end else begin
            while (rq.function_code[2:0] == 3'b000) rq.function_code = 8'($urandom_range(0, 255));
         end
         low  = rq.function_code[2:0];
         mask = 3'($urandom_range(0, 7));
         b = 2'($urandom_range(0, 2));
         while (!low[b]) b = 2'($urandom_range(0, 2));
         mask[b] = 1'b1;
         rq.descriptor[2:0] = mask;
      end else if (kind < 85) begin
         if (limit != 8'hFF) begin
            rq.device_index = 8'($urandom_range(limit + 1, 255));
         end
      end
      return rq;
   endfunction

   task automatic test_directed_requests();
      logic [15:0] ones_value_a;
      logic [15:0] ones_value_b;
      ones_value_a = crc_ones_write_value(8'd0, 16'h0001);
      ones_value_b = crc_ones_write_value(8'd6, 16'hFFFF);
      send_request(make_request(8'd0, FC_READ, make_descriptor(16'h0000, 8'h00, 3'b001), 16'h0));
      send_request(make_request(8'd6, FC_READ, 32'hFFFF_FF01, 16'hFFFF));
      send_request(make_request(8'd7, FC_READ, make_descriptor(16'h0010, 8'h02, 3'b001), 16'h0));
      send_request(make_request(8'd255, FC_WRITE, 32'h0000_0000, 16'h1234));
      send_request(make_request(8'd3, FC_WRITE, 32'h1234_5602, 16'hFFFF));
      send_request(make_request(8'd2, FC_WRITE, make_descriptor(16'h8000, 8'h7F, 3'b100), 16'h0));
      send_request(make_request(8'd1, FC_READ, make_descriptor(16'h0100, 8'h01, 3'b000), 16'h0));
      send_request(make_request(8'd1, FC_READ, make_descriptor(16'h0100, 8'h01, 3'b100), 16'h0));
      send_request(make_request(8'd1, FC_WRITE, make_descriptor(16'h0100, 8'h01, 3'b001), 16'h5));
      send_request(make_request(8'd0, 8'h05, make_descriptor(16'h00FF, 8'h80, 3'b001), 16'hA5A5));
      send_request(make_request(8'd5, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF));
      send_request(make_request(8'd4, 8'h08, make_descriptor(16'h0004, 8'h04, 3'b111), 16'h0));
      send_request(make_request(8'd0, 8'h00, make_descriptor(16'h0000, 8'h00, 3'b111), 16'h0));
      send_request(make_request(8'd2, FC_READ, 32'hABCD_12FB, 16'h5A5A));
      send_request(make_request(8'd0, FC_WRITE, make_descriptor(16'h0001, 8'h00, 3'b010),
                                ones_value_a));
      send_request(make_request(8'd6, FC_WRITE, make_descriptor(16'hFFFF, 8'hFF, 3'b110),
                                ones_value_b));
   endtask

   task automatic test_index_limit_extremes();
      write_max_index(8'h00);
      send_request(make_request(8'd0, FC_READ, make_descriptor(16'h1111, 8'h22, 3'b011), 16'h0));
      send_request(make_request(8'd1, FC_READ, make_descriptor(16'h1111, 8'h22, 3'b011), 16'h0));
      write_max_index(8'hFF);
      send_request(make_request(8'd255, FC_WRITE, make_descriptor(16'h2222, 8'h00, 3'b010),
                                16'h8001));
      send_request(make_request(8'd254, FC_READ, make_descriptor(16'h7FFF, 8'hFF, 3'b001), 16'h0));
      send_request(make_request(8'd128, FC_WRITE, make_descriptor(16'h0000, 8'h00, 3'b110),
                                16'h7FFE));
      write_max_index(8'hFE);
      send_request(make_request(8'd255, FC_READ, make_descriptor(16'h0001, 8'h01, 3'b001), 16'h0));
      send_request(make_request(8'd254, FC_READ, make_descriptor(16'h0001, 8'h01, 3'b001), 16'h0));
   endtask

   task automatic test_random_traffic();
      logic [7:0] setting;
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: setting = 8'hFF;
            1: setting = 8'h00;
            2: setting = MAX_DEVICE_INDEX_RST;
            4: setting = 8'h01;
            5: setting = 8'hFE;
            7: setting = 8'hFF;
            default: setting = 8'($urandom_range(2, 253));
         endcase
         write_max_index(setting);
         burst_mode = (p % 3 == 2);
         repeat (36) send_request(random_request(max_index_setting));
      end
      burst_mode = 1'b0;
   endtask

   task automatic test_receiver_holdoff();
      wait_until_drained();
      holdoff_request = HOLDOFF_LEN;
      burst_mode = 1'b1;
      repeat (12) send_request(random_request(max_index_setting));
      burst_mode = 1'b0;
   endtask

   task automatic test_sender_drain_pause();
      repeat (5) send_request(random_request(max_index_setting));
      wait_until_drained();
      repeat (5) send_request(random_request(max_index_setting));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_requests();
      test_index_limit_extremes();
      test_random_traffic();
      test_receiver_holdoff();
      test_sender_drain_pause();
      wait_until_drained();
      $display("covered %0d requests over %0d limit writes and %0d long receiver hold-offs",
               requests_accepted, config_writes, holdoffs_done);
      $display("%0d beats checked: %0d frames, %0d index, %0d code, %0d crc errors; %0d mismatches",
               beats_checked, good_frames, status_seen[STATUS_BAD_ID], status_seen[STATUS_BAD_FC],
               status_seen[STATUS_BAD_CRC], mismatch_count);
      if (mismatch_count == 0 && frame_beats_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
